>>> sv/rgef_pkg.sv
`timescale 1ns / 1ps

package rgef_pkg;

    localparam int MAX_EXTENTS = 64;
    localparam int ADDR_W      = $clog2(MAX_EXTENTS);
    localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
    localparam int ADDR_BITS   = 64;
    localparam int ID_W        = 32;
    localparam int CONF_W      = 3;
    localparam int EXCL_W      = 6;
    localparam int STATUS_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_CONF      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE_ID   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EXCLUSIONS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_MAP_CONF    = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SIZE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_TOO_FEW  = 2'd3;

    localparam logic KIND_EXCLUSION = 1'b0;
    localparam logic KIND_DONE      = 1'b1;

    localparam logic [EXCL_W-1:0] RESET_MAX_EXCLUSIONS = 6'd63;
    localparam logic [CONF_W-1:0] RESET_MAP_CONF       = 3'd7;

    typedef struct packed {
        logic                 extent_present;
        logic [ADDR_BITS-1:0] extent_lo;
        logic [ADDR_BITS-1:0] extent_hi;
        logic [ID_W-1:0]      extent_id;
        logic [CONF_W-1:0]    extent_confidence;
        logic                 last_extent;
    } in_word_t;

    typedef struct packed {
        logic                 record_kind;
        logic [ADDR_BITS-1:0] exclusion_lo;
        logic [ADDR_BITS-1:0] exclusion_hi;
        logic [CONF_W-1:0]    result_confidence;
        logic [ID_W-1:0]      ram_extent_id;
        logic [ID_W-1:0]      size_source_id;
        logic [STATUS_W-1:0]  run_status;
        logic [EXCL_W-1:0]    exclusion_count;
        logic                 last_result;
    } out_word_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] lo;
        logic [ADDR_BITS-1:0] hi;
        logic [ID_W-1:0]      id;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        entry_t            wdata;
        logic [ADDR_W-1:0] raddr;
    } ram_ctl_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_INS_WAIT,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_SW_START,
        ST_SW_FIRST,
        ST_SW_WAIT,
        ST_SW_CMP,
        ST_SW_HOLE,
        ST_SW_EMIT,
        ST_DONE
    } state_t;

endpackage

>>> sv/rgef_if.sv
`timescale 1ns / 1ps

interface rgef_in_if;
    logic               valid;
    logic               ready;
    rgef_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rgef_out_if;
    logic                valid;
    logic                ready;
    rgef_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/rgef_ram.sv
`timescale 1ns / 1ps

module rgef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/ram_gap_exclusion_finder_unit.sv
// Channel    Dir  Word        Accepted when
// in_word    in   in_word_t   in_word.valid & in_word.ready
// out_word   out  out_word_t  out_word.valid & out_word.ready
// cfg        in   index/data  cfg_we high (only while idle, a rule for the user; not enforced)
//
// A dropped item holds the input through LOAD only. A stored item goes through LOAD,
// INS_WAIT and INS_CMP per stored extent that moves up, ending in INS_CMP or INS_PUT
// (one RAM with one write and one registered read port). The last item then sweeps
// the sorted store: SW_START, SW_FIRST, SW_WAIT and SW_CMP per further extent and
// SW_HOLE and SW_EMIT per gap, then the done word; each word waits while out_word is
// stalled. Reset clears the run; store entries are read only after being written.
`timescale 1ns / 1ps

module ram_gap_exclusion_finder_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rgef_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rgef_pkg::CFG_DATA_W-1:0]     cfg_data,
    rgef_in_if.sink                             in_word,
    rgef_out_if.source                          out_word
);

    rgef_pkg::state_t    state_reg, state_next;
    rgef_pkg::in_word_t  item_reg, item_next;
    rgef_pkg::out_word_t out_data_reg, out_data_next;
    rgef_pkg::entry_t    rd_entry;
    rgef_pkg::ram_ctl_t  ram_ctl;

    logic [rgef_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                           ovf_reg, ovf_next;
    logic [rgef_pkg::CONF_W-1:0]    map_conf_reg, map_conf_next;
    logic [rgef_pkg::ADDR_W-1:0]    j_reg, j_next;
    logic [rgef_pkg::CNT_W-1:0]     i_reg, i_next;
    logic [rgef_pkg::EXCL_W-1:0]    n_reg, n_next;
    logic [rgef_pkg::ADDR_BITS-1:0] cur_hi_reg, cur_hi_next;
    logic [rgef_pkg::ID_W-1:0]      cur_id_reg, cur_id_next;
    logic [rgef_pkg::ID_W-1:0]      rec_id_reg, rec_id_next;
    logic [rgef_pkg::ADDR_BITS-1:0] gap_lo_reg, gap_lo_next;
    logic [rgef_pkg::ADDR_BITS-1:0] gap_hi_reg, gap_hi_next;
    logic [rgef_pkg::ADDR_BITS-1:0] hole_lo_reg, hole_lo_next;
    logic [rgef_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic                           out_valid_reg, out_valid_next;

    logic [rgef_pkg::ADDR_BITS-1:0] ks_reg;
    logic [rgef_pkg::CONF_W-1:0]    kconf_reg;
    logic [rgef_pkg::ID_W-1:0]      ksid_reg;
    logic [rgef_pkg::EXCL_W-1:0]    max_excl_reg;
    logic [rgef_pkg::CONF_W-1:0]    init_conf_reg;

    logic [rgef_pkg::ENTRY_W-1:0]   ram_rdata;
    logic                           in_acc;
    logic                           slot_free;
    logic                           item_ok;
    logic                           store_full;
    logic                           gap_found;
    logic                           hole_ok;
    logic                           emit_excl;
    logic                           emit_done;
    logic                           more;
    logic                           shift_up;
    logic [rgef_pkg::EXCL_W-1:0]    n_after;
    logic [rgef_pkg::CNT_W-1:0]     i_inc;
    logic [rgef_pkg::CONF_W-1:0]    econf;
    logic [rgef_pkg::STATUS_W-1:0]  run_status;
    logic [rgef_pkg::ADDR_BITS-1:0] cur_hi_inc;
    logic [rgef_pkg::CONF_W-1:0]    conf_min;

    rgef_ram #(
        .WIDTH (rgef_pkg::ENTRY_W),
        .DEPTH (rgef_pkg::MAX_EXTENTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_ctl.we),
        .waddr (ram_ctl.waddr),
        .wdata (ram_ctl.wdata),
        .raddr (ram_ctl.raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry   = rgef_pkg::entry_t'(ram_rdata);
    assign in_word.ready = (state_reg == rgef_pkg::ST_IDLE);
    assign in_acc     = in_word.valid && in_word.ready;
    assign slot_free  = !out_valid_reg || out_word.ready;
    assign item_ok    = item_reg.extent_present && (item_reg.extent_hi >= item_reg.extent_lo);
    assign store_full = (count_reg == rgef_pkg::CNT_W'(rgef_pkg::MAX_EXTENTS));
    assign shift_up   = (rd_entry.lo > item_reg.extent_lo);
    assign cur_hi_inc = cur_hi_reg + rgef_pkg::ADDR_BITS'(1);
    assign gap_found  = (cur_hi_reg != '1) && (rd_entry.lo > cur_hi_inc);
    assign hole_ok    = (gap_hi_reg >= hole_lo_reg);
    assign emit_excl  = (state_reg == rgef_pkg::ST_SW_EMIT) && hole_ok && slot_free;
    assign emit_done  = (state_reg == rgef_pkg::ST_DONE) && slot_free;
    assign n_after    = emit_excl ? n_reg + rgef_pkg::EXCL_W'(1) : n_reg;
    assign i_inc      = i_reg + rgef_pkg::CNT_W'(1);
    assign more       = (i_inc < count_reg) && (n_after < max_excl_reg);
    assign econf      = (kconf_reg < map_conf_reg) ? kconf_reg : map_conf_reg;
    assign conf_min   = (item_reg.extent_confidence < map_conf_reg) ?
                        item_reg.extent_confidence : map_conf_reg;

    always_comb
    begin
        priority if (ks_reg == '0)
        begin
            run_status = rgef_pkg::STATUS_NO_SIZE;
        end
        else if (ovf_reg)
        begin
            run_status = rgef_pkg::STATUS_OVERFLOW;
        end
        else if (count_reg < rgef_pkg::CNT_W'(2))
        begin
            run_status = rgef_pkg::STATUS_TOO_FEW;
        end
        else
        begin
            run_status = rgef_pkg::STATUS_OK;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rgef_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = rgef_pkg::ST_LOAD;
                end
            end
            rgef_pkg::ST_LOAD:
            begin
                if (!item_ok || store_full)
                begin
                    state_next = item_reg.last_extent ? rgef_pkg::ST_SW_START
                                                      : rgef_pkg::ST_IDLE;
                end
                else if (count_reg == '0)
                begin
                    state_next = rgef_pkg::ST_INS_PUT;
                end
                else
                begin
                    state_next = rgef_pkg::ST_INS_WAIT;
                end
            end
            rgef_pkg::ST_INS_WAIT:
            begin
                state_next = rgef_pkg::ST_INS_CMP;
            end
            rgef_pkg::ST_INS_CMP:
            begin
                if (shift_up)
                begin
                    state_next = (j_reg == rgef_pkg::ADDR_W'(1)) ? rgef_pkg::ST_INS_PUT
                                                                 : rgef_pkg::ST_INS_WAIT;
                end
                else
                begin
                    state_next = item_reg.last_extent ? rgef_pkg::ST_SW_START
                                                      : rgef_pkg::ST_IDLE;
                end
            end
            rgef_pkg::ST_INS_PUT:
            begin
                state_next = item_reg.last_extent ? rgef_pkg::ST_SW_START
                                                  : rgef_pkg::ST_IDLE;
            end
            rgef_pkg::ST_SW_START:
            begin
                state_next = (run_status == rgef_pkg::STATUS_OK) ? rgef_pkg::ST_SW_FIRST
                                                                 : rgef_pkg::ST_DONE;
            end
            rgef_pkg::ST_SW_FIRST:
            begin
                state_next = (max_excl_reg == '0) ? rgef_pkg::ST_DONE
                                                  : rgef_pkg::ST_SW_WAIT;
            end
            rgef_pkg::ST_SW_WAIT:
            begin
                state_next = rgef_pkg::ST_SW_CMP;
            end
            rgef_pkg::ST_SW_CMP:
            begin
                if (gap_found)
                begin
                    state_next = rgef_pkg::ST_SW_HOLE;
                end
                else
                begin
                    state_next = more ? rgef_pkg::ST_SW_WAIT : rgef_pkg::ST_DONE;
                end
            end
            rgef_pkg::ST_SW_HOLE:
            begin
                state_next = rgef_pkg::ST_SW_EMIT;
            end
            rgef_pkg::ST_SW_EMIT:
            begin
                if (!hole_ok || slot_free)
                begin
                    state_next = more ? rgef_pkg::ST_SW_WAIT : rgef_pkg::ST_DONE;
                end
            end
            rgef_pkg::ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = rgef_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rgef_pkg::ST_IDLE;
            end
        endcase
    end

    // store port
    always_comb
    begin
        ram_ctl.we    = 1'b0;
        ram_ctl.waddr = j_reg;
        ram_ctl.wdata = rd_entry;
        ram_ctl.raddr = i_reg[rgef_pkg::ADDR_W-1:0];
        unique case (state_reg)
            rgef_pkg::ST_INS_WAIT:
            begin
                ram_ctl.raddr = j_reg - rgef_pkg::ADDR_W'(1);
            end
            rgef_pkg::ST_INS_CMP:
            begin
                ram_ctl.raddr = j_reg - rgef_pkg::ADDR_W'(1);
                ram_ctl.we    = 1'b1;
                if (!shift_up)
                begin
                    ram_ctl.wdata = '{lo: item_reg.extent_lo, hi: item_reg.extent_hi,
                                      id: item_reg.extent_id};
                end
            end
            rgef_pkg::ST_INS_PUT:
            begin
                ram_ctl.we    = 1'b1;
                ram_ctl.wdata = '{lo: item_reg.extent_lo, hi: item_reg.extent_hi,
                                  id: item_reg.extent_id};
            end
            rgef_pkg::ST_SW_START:
            begin
                ram_ctl.raddr = '0;
            end
            default:
            begin
                ram_ctl.we = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        item_next     = item_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        map_conf_next = map_conf_reg;
        j_next        = j_reg;
        i_next        = i_reg;
        n_next        = n_reg;
        cur_hi_next   = cur_hi_reg;
        cur_id_next   = cur_id_reg;
        rec_id_next   = rec_id_reg;
        gap_lo_next   = gap_lo_reg;
        gap_hi_next   = gap_hi_reg;
        hole_lo_next  = hole_lo_reg;
        status_next   = status_reg;
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg && !out_word.ready;

        unique case (state_reg)
            rgef_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    item_next = in_word.data;
                end
                if (cfg_we && (cfg_index == rgef_pkg::CFG_INIT_MAP_CONF) &&
                    (count_reg == '0) && !ovf_reg)
                begin
                    map_conf_next = cfg_data[rgef_pkg::CONF_W-1:0];
                end
            end
            rgef_pkg::ST_LOAD:
            begin
                j_next = count_reg[rgef_pkg::ADDR_W-1:0];
                if (item_ok && store_full)
                begin
                    ovf_next = 1'b1;
                end
            end
            rgef_pkg::ST_INS_CMP:
            begin
                if (shift_up)
                begin
                    j_next = j_reg - rgef_pkg::ADDR_W'(1);
                end
                else
                begin
                    count_next    = count_reg + rgef_pkg::CNT_W'(1);
                    map_conf_next = conf_min;
                end
            end
            rgef_pkg::ST_INS_PUT:
            begin
                count_next    = count_reg + rgef_pkg::CNT_W'(1);
                map_conf_next = conf_min;
            end
            rgef_pkg::ST_SW_START:
            begin
                status_next = run_status;
                n_next      = '0;
            end
            rgef_pkg::ST_SW_FIRST:
            begin
                cur_hi_next = rd_entry.hi;
                cur_id_next = rd_entry.id;
                i_next      = rgef_pkg::CNT_W'(1);
            end
            rgef_pkg::ST_SW_CMP:
            begin
                gap_lo_next = cur_hi_inc;
                gap_hi_next = rd_entry.lo - rgef_pkg::ADDR_BITS'(1);
                rec_id_next = cur_id_reg;
                if (rd_entry.hi > cur_hi_reg)
                begin
                    cur_hi_next = rd_entry.hi;
                    cur_id_next = rd_entry.id;
                end
                if (!gap_found)
                begin
                    i_next = i_inc;
                end
            end
            rgef_pkg::ST_SW_HOLE:
            begin
                hole_lo_next = (gap_lo_reg > ks_reg) ?
                               gap_lo_reg - ks_reg + rgef_pkg::ADDR_BITS'(1) : '0;
            end
            rgef_pkg::ST_SW_EMIT:
            begin
                if (emit_excl)
                begin
                    n_next         = n_after;
                    out_valid_next = 1'b1;
                    out_data_next  = '{record_kind:       rgef_pkg::KIND_EXCLUSION,
                                       exclusion_lo:      hole_lo_reg,
                                       exclusion_hi:      gap_hi_reg,
                                       result_confidence: econf,
                                       ram_extent_id:     rec_id_reg,
                                       size_source_id:    ksid_reg,
                                       run_status:        rgef_pkg::STATUS_OK,
                                       exclusion_count:   '0,
                                       last_result:       1'b0};
                end
                if (!hole_ok || slot_free)
                begin
                    i_next = i_inc;
                end
            end
            rgef_pkg::ST_DONE:
            begin
                if (emit_done)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{record_kind:       rgef_pkg::KIND_DONE,
                                       exclusion_lo:      '0,
                                       exclusion_hi:      '0,
                                       result_confidence: econf,
                                       ram_extent_id:     '0,
                                       size_source_id:    ksid_reg,
                                       run_status:        status_reg,
                                       exclusion_count:   n_reg,
                                       last_result:       1'b1};
                    count_next    = '0;
                    ovf_next      = 1'b0;
                    map_conf_next = init_conf_reg;
                end
            end
            default:
            begin
                j_next = j_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rgef_pkg::ST_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            map_conf_reg  <= rgef_pkg::RESET_MAP_CONF;
            j_reg         <= '0;
            i_reg         <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            map_conf_reg  <= map_conf_next;
            j_reg         <= j_next;
            i_reg         <= i_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        cur_hi_reg   <= cur_hi_next;
        cur_id_reg   <= cur_id_next;
        rec_id_reg   <= rec_id_next;
        gap_lo_reg   <= gap_lo_next;
        gap_hi_reg   <= gap_hi_next;
        hole_lo_reg  <= hole_lo_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ks_reg        <= '0;
            kconf_reg     <= '0;
            ksid_reg      <= '0;
            max_excl_reg  <= rgef_pkg::RESET_MAX_EXCLUSIONS;
            init_conf_reg <= rgef_pkg::RESET_MAP_CONF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rgef_pkg::CFG_KERNEL_SIZE:
                begin
                    ks_reg <= cfg_data;
                end
                rgef_pkg::CFG_KERNEL_CONF:
                begin
                    kconf_reg <= cfg_data[rgef_pkg::CONF_W-1:0];
                end
                rgef_pkg::CFG_KERNEL_SIZE_ID:
                begin
                    ksid_reg <= cfg_data[rgef_pkg::ID_W-1:0];
                end
                rgef_pkg::CFG_MAX_EXCLUSIONS:
                begin
                    max_excl_reg <= cfg_data[rgef_pkg::EXCL_W-1:0];
                end
                rgef_pkg::CFG_INIT_MAP_CONF:
                begin
                    init_conf_reg <= cfg_data[rgef_pkg::CONF_W-1:0];
                end
                default:
                begin
                    init_conf_reg <= init_conf_reg;
                end
            endcase
        end
    end

    assign out_word.valid = out_valid_reg;
    assign out_word.data  = out_data_reg;

endmodule
